// ===== design/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdc_pkg: shared types and constants of the radix digit converter
// Field widths, configuration register indexes, special characters and the
// control group that drives the row of digit cells.
// ----------------------------------------------------------------------------
package rdc_pkg;

  // Fixed field widths.
  localparam int DIGIT_W     = 4;
  localparam int CHAR_W      = 8;
  localparam int RADIX_W     = 5;
  localparam int COUNT_W     = 7;
  localparam int VALUE_W     = 64;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int ALPHA_SLOTS = 16;
  localparam int HALF_SLOTS  = 8;

  // Smallest usable alphabet.
  localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

  // Characters that may not appear in an alphabet.
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // Offset added to a negative value in signed mode (32-bit wrap).
  localparam logic [VALUE_W-1:0] WRAP_ADD = 64'h0000_0001_0000_0000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA_LOW  = 2'd0,
    CFG_ALPHA_HIGH = 2'd1,
    CFG_RADIX_LEN  = 2'd2
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  // Control group broadcast to every digit cell.
  typedef struct packed {
    logic clear;  // zero the digit
    logic conv;   // double-and-add step when the token arrives
    logic shift;  // take the digit of the cell below
  } cell_ctrl_t;

  // Symbol lookup in the two alphabet registers.
  function automatic logic [CHAR_W-1:0] sym_at(input logic [CFG_DATA_W-1:0] lo,
                                               input logic [CFG_DATA_W-1:0] hi,
                                               input logic [DIGIT_W-1:0] idx);
    logic [CFG_DATA_W-1:0] word;
    word = idx[DIGIT_W-1] ? hi : lo;
    return word[idx[DIGIT_W-2:0]*CHAR_W +: CHAR_W];
  endfunction

endpackage

// ===== design/rdc_if.sv =====
// ----------------------------------------------------------------------------
// rdc_if: channel interfaces of the radix digit converter
// Valid/ready channels for conversion requests and for digit results.
// ----------------------------------------------------------------------------
interface rdc_in_if;
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [63:0]          value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface rdc_out_if;
  logic                 valid;
  logic                 ready;
  logic [7:0]           digit_char;
  logic                 last_digit;
  logic [6:0]           digit_count;
  logic                 alphabet_error;

  modport source (output valid, output digit_char, output last_digit,
                  output digit_count, output alphabet_error, input ready);
  modport sink   (input valid, input digit_char, input last_digit,
                  input digit_count, input alphabet_error, output ready);
endinterface

// ===== design/rdc_cell.sv =====
// ----------------------------------------------------------------------------
// rdc_cell: one radix digit of the conversion chain
// Doubles its digit and adds the incoming carry, reduces modulo the radix and
// passes the carry with its token to the next cell in the following cycle.
// In the output phase the cell takes the digit of the cell below it.
// ----------------------------------------------------------------------------
module rdc_cell
  import rdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cell_ctrl_t         ctrl,
  input  logic [RADIX_W-1:0] radix,
  input  logic               carry_in,
  input  logic               tok_in,
  input  logic [DIGIT_W-1:0] digit_in,
  output logic [DIGIT_W-1:0] digit,
  output logic               carry_out,
  output logic               tok_out
);

  logic [DIGIT_W-1:0] digit_r;
  logic               carry_r;
  logic               tok_r;
  logic [RADIX_W-1:0] dbl;
  logic [RADIX_W-1:0] red;
  logic               ge;

  // Double-and-add with one conditional subtract of the radix.
  always_comb begin
    dbl = {digit_r, carry_in};
    ge  = (dbl >= radix);
    red = ge ? (dbl - radix) : dbl;
  end

  // Token travels one cell per cycle; reset clears it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= ctrl.conv & tok_in;
    end
  end

  // Digit and carry storage.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit_r <= '0;
    end else if (ctrl.conv && tok_in) begin
      digit_r <= red[DIGIT_W-1:0];
      carry_r <= ge;
    end else if (ctrl.shift) begin
      digit_r <= digit_in;
    end
  end

  assign digit     = digit_r;
  assign carry_out = carry_r;
  assign tok_out   = tok_r;

endmodule

// ===== design/rdc_alpha_check.sv =====
// ----------------------------------------------------------------------------
// rdc_alpha_check: alphabet validation
// Flags an alphabet as usable when its length is in range and no symbol in
// use is a zero byte, a sign character or a repeat of another symbol.
// ----------------------------------------------------------------------------
module rdc_alpha_check
  import rdc_pkg::*;
#(
  parameter int MAX_SYMBOLS = 16
) (
  input  logic [CFG_DATA_W-1:0] alpha_low,
  input  logic [CFG_DATA_W-1:0] alpha_high,
  input  logic [RADIX_W-1:0]    radix_len,
  output logic                  alpha_ok
);

  logic [CHAR_W-1:0]      sym [ALPHA_SLOTS];
  logic [ALPHA_SLOTS-1:0] in_use;
  logic                   len_ok;
  logic                   bad;

  always_comb begin
    len_ok = (radix_len >= MIN_RADIX) && (radix_len <= RADIX_W'(MAX_SYMBOLS));
    bad    = 1'b0;
    for (int i = 0; i < ALPHA_SLOTS; i++) begin
      sym[i]    = sym_at(alpha_low, alpha_high, DIGIT_W'(i));
      in_use[i] = (RADIX_W'(i) < radix_len);
    end
    // Forbidden characters and pairwise repeats among the symbols in use.
    for (int i = 0; i < ALPHA_SLOTS; i++) begin
      if (in_use[i] && (sym[i] == CHAR_NUL || sym[i] == CHAR_PLUS ||
                        sym[i] == CHAR_MINUS)) begin
        bad = 1'b1;
      end
      for (int j = i + 1; j < ALPHA_SLOTS; j++) begin
        if (in_use[j] && sym[i] == sym[j]) begin
          bad = 1'b1;
        end
      end
    end
    alpha_ok = len_ok && !bad;
  end

endmodule

// ===== design/radix_digit_converter.sv =====
// ----------------------------------------------------------------------------
// radix_digit_converter: integer to radix string conversion
// Converts one number per transaction into alphabet symbols, most
// significant digit first, on a row of radix digit cells.
// ----------------------------------------------------------------------------
// Usage:
//   Write the alphabet (index 0 and 1) and its length (index 2) on the cfg
//   port while the block is idle. Each input transaction carries cmd and
//   value; the output channel returns one transaction per digit, the last
//   one flagged and carrying the digit count. A bad alphabet gives a single
//   error transaction with count 0.
// Timing:
//   The value bits enter the cell row MSB first, one per cycle, and ripple
//   through the MAX_DIGITS cells one cell per cycle. Leading zero digits are
//   then shifted out at one cell per cycle, after which the digits are sent
//   one by one, each held in the output register while the receiver stalls.
//   Items are handled one at a time.
// Reset and stalls:
//   Reset clears the sequencer, the configuration and the control registers.
//   A stalled receiver holds the output digit and any state with a result to
//   load; the next request is taken as soon as the last digit is loaded.
// ----------------------------------------------------------------------------
module radix_digit_converter
  import rdc_pkg::*;
#(
  parameter int MAX_SYMBOLS = 16,
  parameter int MAX_DIGITS  = 64,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rdc_in_if.sink                in_chan,
  rdc_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(VALUE_WIDTH + MAX_DIGITS);
  localparam int RW = $clog2(MAX_DIGITS + 1);
  localparam int TOP = MAX_DIGITS - 1;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] alpha_low_r;
  logic [CFG_DATA_W-1:0] alpha_high_r;
  logic [RADIX_W-1:0]    radix_len_r;
  logic                  alpha_ok_w;
  logic                  alpha_ok_r;

  // Sequencer and datapath.
  state_t                state_r, state_nxt;
  logic [CW-1:0]         cnt_r;
  logic [RW-1:0]         rem_r;
  logic [RW-1:0]         count_r;
  logic [VALUE_WIDTH-1:0] vshift_r;
  logic [VALUE_WIDTH-1:0] v_in;
  logic [VALUE_W-1:0]    v_sum;
  logic [VALUE_WIDTH-1:0] v_adj;

  // Output register.
  logic                  out_valid_r;
  logic [CHAR_W-1:0]     out_char_r;
  logic                  out_last_r;
  logic [COUNT_W-1:0]    out_cnt_r;
  logic                  out_err_r;

  // Control.
  cell_ctrl_t            cell_ctrl;
  logic                  in_accept;
  logic                  out_free;
  logic                  ld_err;
  logic                  ld_dig;
  logic                  tok0;
  logic                  conv_done;
  logic                  rem_last;
  logic                  top_zero;

  // Cell row wiring.
  logic [DIGIT_W-1:0]    digit_w [MAX_DIGITS];
  logic                  carry_w [MAX_DIGITS];
  logic                  tok_w   [MAX_DIGITS];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_low_r  <= '0;
      alpha_high_r <= '0;
      radix_len_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALPHA_LOW:  alpha_low_r  <= cfg_data;
        CFG_ALPHA_HIGH: alpha_high_r <= cfg_data;
        CFG_RADIX_LEN:  radix_len_r  <= cfg_data[RADIX_W-1:0];
        default: ;
      endcase
    end
  end

  rdc_alpha_check #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_alpha_check (
    .alpha_low  (alpha_low_r),
    .alpha_high (alpha_high_r),
    .radix_len  (radix_len_r),
    .alpha_ok   (alpha_ok_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_ok_r <= 1'b0;
    end else begin
      alpha_ok_r <= alpha_ok_w;
    end
  end

  // Signed mode: a negative value gets 2^32 added within VALUE_WIDTH bits.
  always_comb begin
    v_in  = in_chan.value[VALUE_WIDTH-1:0];
    v_sum = VALUE_W'(v_in) + WRAP_ADD;
    v_adj = (in_chan.cmd && v_in[VALUE_WIDTH-1]) ? v_sum[VALUE_WIDTH-1:0] : v_in;
  end

  // Status terms shared by the sequencer blocks.
  assign in_accept = in_chan.valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_chan.ready;
  assign conv_done = (cnt_r == CW'(VALUE_WIDTH + MAX_DIGITS - 2));
  assign rem_last  = (rem_r == RW'(1));
  assign top_zero  = (digit_w[TOP] == '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (alpha_ok_r) state_nxt = ST_CONV;
        else if (out_free) state_nxt = ST_IDLE;
      end
      ST_CONV: begin
        if (conv_done) state_nxt = ST_SKIP;
      end
      ST_SKIP: begin
        if (!top_zero || rem_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && rem_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    cell_ctrl = '0;
    ld_err    = 1'b0;
    ld_dig    = 1'b0;
    tok0      = 1'b0;
    case (state_r)
      ST_CHECK: begin
        cell_ctrl.clear = 1'b1;
        ld_err          = !alpha_ok_r && out_free;
      end
      ST_CONV: begin
        cell_ctrl.conv = 1'b1;
        tok0           = (cnt_r < CW'(VALUE_WIDTH));
      end
      ST_SKIP: begin
        cell_ctrl.shift = top_zero && !rem_last;
      end
      ST_EMIT: begin
        ld_dig          = out_free;
        cell_ctrl.shift = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Cycle counter of the conversion phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (state_r == ST_CONV) begin
      cnt_r <= cnt_r + CW'(1);
    end else begin
      cnt_r <= '0;
    end
  end

  // Digits left in the row, and the digit count once leading zeros are gone.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= '0;
      count_r <= '0;
    end else begin
      if (state_r == ST_CONV && conv_done) begin
        rem_r <= RW'(MAX_DIGITS);
      end else if (cell_ctrl.shift) begin
        rem_r <= rem_r - RW'(1);
      end
      if (state_r == ST_SKIP && !cell_ctrl.shift) begin
        count_r <= rem_r;
      end
    end
  end

  // Value bits feed the first cell MSB first.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      vshift_r <= v_adj;
    end else if (state_r == ST_CONV) begin
      vshift_r <= {vshift_r[VALUE_WIDTH-2:0], 1'b0};
    end
  end

  // Row of digit cells; cell 0 holds the least significant digit.
  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      rdc_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (cell_ctrl),
        .radix     (radix_len_r),
        .carry_in  (vshift_r[VALUE_WIDTH-1]),
        .tok_in    (tok0),
        .digit_in  ({DIGIT_W{1'b0}}),
        .digit     (digit_w[i]),
        .carry_out (carry_w[i]),
        .tok_out   (tok_w[i])
      );
    end else begin : g_next
      rdc_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (cell_ctrl),
        .radix     (radix_len_r),
        .carry_in  (carry_w[i-1]),
        .tok_in    (tok_w[i-1]),
        .digit_in  (digit_w[i-1]),
        .digit     (digit_w[i]),
        .carry_out (carry_w[i]),
        .tok_out   (tok_w[i])
      );
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_err || ld_dig) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_err) begin
      out_char_r <= CHAR_NUL;
      out_last_r <= 1'b1;
      out_cnt_r  <= '0;
      out_err_r  <= 1'b1;
    end else if (ld_dig) begin
      out_char_r <= sym_at(alpha_low_r, alpha_high_r, digit_w[TOP]);
      out_last_r <= rem_last;
      out_cnt_r  <= rem_last ? COUNT_W'(count_r) : '0;
      out_err_r  <= 1'b0;
    end
  end

  assign in_chan.ready           = (state_r == ST_IDLE);
  assign out_chan.valid          = out_valid_r;
  assign out_chan.digit_char     = out_char_r;
  assign out_chan.last_digit     = out_last_r;
  assign out_chan.digit_count    = out_cnt_r;
  assign out_chan.alphabet_error = out_err_r;

endmodule

// ===== design/rdc_checker.sv =====
// ----------------------------------------------------------------------------
// rdc_checker: port-level checks of the radix digit converter
// Watches the result channel for a held payload under stall and for
// consistent marking of last digits, counts and error results.
// ----------------------------------------------------------------------------
module rdc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] digit_char,
  input logic       last_digit,
  input logic [6:0] digit_count,
  input logic       alphabet_error
);

  // A stalled result transaction keeps its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(digit_char) &&
      $stable(last_digit) && $stable(digit_count) && $stable(alphabet_error))
    else $error("result payload changed while stalled");

  // An error result is a lone last transaction with no symbol and no count.
  a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && alphabet_error |-> last_digit && digit_count == 7'd0 &&
      digit_char == 8'd0)
    else $error("malformed error result");

  // Only the last digit of a conversion carries a count.
  a_count_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last_digit |-> digit_count == 7'd0 && !alphabet_error)
    else $error("count or error flag on a non-final digit");

  // The final digit of a good conversion reports between 1 and 64 digits.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_digit && !alphabet_error |->
      digit_count != 7'd0 && digit_count <= 7'd64)
    else $error("digit count out of range");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .digit_char     (out_chan.digit_char),
  .last_digit     (out_chan.last_digit),
  .digit_count    (out_chan.digit_count),
  .alphabet_error (out_chan.alphabet_error)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the radix digit converter
// Writes a range of alphabets, good and bad, sends conversion requests and
// compares every digit transaction against a predictor of the conversion,
// with random gaps on the request side and random stalls on the digit side.
// ----------------------------------------------------------------------------
module testbench;
  import rdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int RANDOM_PHASES  = 14;

  // One digit transaction as the converter should send it.
  typedef struct {
    logic [7:0] digit_char;
    logic       last_digit;
    logic [6:0] digit_count;
    logic       alphabet_error;
  } digit_result_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rdc_in_if  req_if ();
  rdc_out_if dig_if ();

  radix_digit_converter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (req_if),
    .out_chan  (dig_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the alphabet and its length.
  logic [127:0] alphabet_symbols = '0;
  logic [4:0]   alphabet_length  = '0;

  digit_result_t expected_digits[$];
  int  mismatch_count = 0;
  int  quiet_cycles   = 0;
  int  next_gap       = 0;
  bit  req_held       = 0;
  bit  calm           = 0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Symbol i of the shadow alphabet.
  function automatic logic [7:0] symbol_of(input int i);
    return alphabet_symbols[8*i +: 8];
  endfunction

  // An alphabet is usable when it has 2 to 16 distinct symbols, none of
  // which is a sign character or a zero byte.
  function automatic bit alphabet_usable();
    int n;
    logic [7:0] c;
    n = alphabet_length;
    if (n < 2 || n > ALPHA_SLOTS) return 0;
    for (int i = 0; i < n; i++) begin
      c = symbol_of(i);
      if (c == CHAR_NUL || c == CHAR_PLUS || c == CHAR_MINUS) return 0;
      for (int j = i + 1; j < n; j++) begin
        if (symbol_of(j) == c) return 0;
      end
    end
    return 1;
  endfunction

  // Work out the digit transactions of one request and queue them.
  function automatic void predict_digits(input logic cmd, input logic [63:0] value);
    logic [63:0]  v;
    logic [63:0]  radix;
    logic [3:0]   cells [64];
    int           n;
    digit_result_t r;
    if (!alphabet_usable()) begin
      r.digit_char     = '0;
      r.last_digit     = 1'b1;
      r.digit_count    = '0;
      r.alphabet_error = 1'b1;
      expected_digits.push_back(r);
      return;
    end
    v = value;
    // Signed mode: a negative value wraps by 2^32.
    if (cmd && v[63]) v = v + WRAP_ADD;
    radix = 64'(alphabet_length);
    n = 0;
    do begin
      cells[n] = 4'(v % radix);
      v = v / radix;
      n++;
    end while (v != 0 && n < 64);
    // Most significant digit first.
    for (int k = 0; k < n; k++) begin
      r.digit_char     = symbol_of(cells[n - 1 - k]);
      r.last_digit     = (k == n - 1);
      r.digit_count    = (k == n - 1) ? 7'(n) : 7'd0;
      r.alphabet_error = 1'b0;
      expected_digits.push_back(r);
    end
  endfunction

  // Gap before the next request: mostly none, sometimes long.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [127:0] pack_alphabet(input string s);
    logic [127:0] a;
    a = '0;
    for (int i = 0; i < s.len() && i < ALPHA_SLOTS; i++) a[8*i +: 8] = s[i];
    return a;
  endfunction

  // Send one request and queue its predicted digits on acceptance.
  task automatic send_request(input logic cmd, input logic [63:0] value);
    repeat (next_gap) @(posedge clk);
    req_if.valid <= 1'b1;
    req_if.cmd   <= cmd;
    req_if.value <= value;
    do @(posedge clk); while (!req_if.ready);
    predict_digits(cmd, value);
    next_gap = pick_gap();
    // Keep valid high only when the next transaction follows at once.
    req_held = (next_gap == 0);
    if (!req_held) req_if.valid <= 1'b0;
  endtask

  // Stop requesting and wait until every expected digit has arrived.
  task automatic drain_results();
    if (req_held) begin
      req_if.valid <= 1'b0;
      req_held = 0;
    end
    while (expected_digits.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_ALPHA_LOW:  alphabet_symbols[63:0]   = data;
      CFG_ALPHA_HIGH: alphabet_symbols[127:64] = data;
      CFG_RADIX_LEN:  alphabet_length          = data[4:0];
      default: ;
    endcase
  endtask

  // Load a new alphabet once the converter has gone idle.
  task automatic set_alphabet(input logic [127:0] symbols, input logic [4:0] length);
    drain_results();
    write_reg(CFG_ALPHA_LOW, symbols[63:0]);
    write_reg(CFG_ALPHA_HIGH, symbols[127:64]);
    write_reg(CFG_RADIX_LEN, 64'(length));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] random_value();
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 300));
      1: return {32'hFFFF_FFFF, 32'($urandom)};
      2: return {32'($urandom), 32'($urandom)} | 64'h8000_0000_0000_0000;
      3: return {32'($urandom), 32'($urandom)} >> $urandom_range(0, 63);
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  // Random alphabet of random length; a bad one breaks one rule.
  task automatic set_random_alphabet(input bit make_bad);
    bit           used [256];
    logic [127:0] a;
    int           n;
    int           c;
    int           pos;
    used = '{default: 0};
    used[CHAR_NUL]   = 1;
    used[CHAR_PLUS]  = 1;
    used[CHAR_MINUS] = 1;
    n = $urandom_range(2, ALPHA_SLOTS);
    for (int i = 0; i < ALPHA_SLOTS; i++) begin
      if (i < n) begin
        do c = $urandom_range(1, 255); while (used[c]);
        used[c] = 1;
        a[8*i +: 8] = 8'(c);
      end else begin
        // Unused slots hold anything, bad characters included.
        a[8*i +: 8] = 8'($urandom);
      end
    end
    if (make_bad) begin
      case ($urandom_range(0, 3))
        0: begin
          pos = $urandom_range(0, n - 1);
          case ($urandom_range(0, 2))
            0: a[8*pos +: 8] = CHAR_NUL;
            1: a[8*pos +: 8] = CHAR_PLUS;
            default: a[8*pos +: 8] = CHAR_MINUS;
          endcase
        end
        1: begin
          pos = $urandom_range(1, n - 1);
          c = $urandom_range(0, pos - 1);
          a[8*pos +: 8] = a[8*c +: 8];
        end
        2: n = $urandom_range(0, 1);
        default: n = $urandom_range(ALPHA_SLOTS + 1, 31);
      endcase
    end
    set_alphabet(a, 5'(n));
  endtask

  // Registers at reset describe an empty alphabet, which must be rejected.
  task automatic test_reset_alphabet();
    send_request(1'b0, 64'd12345);
  endtask

  // Radix 2: zero, the longest numbers and the signed wrap.
  task automatic test_binary_radix();
    set_alphabet(pack_alphabet("01"), 5'd2);
    send_request(1'b0, 64'd0);
    send_request(1'b0, '1);
    send_request(1'b1, '1);
    send_request(1'b1, 64'h8000_0000_0000_0000);
  endtask

  // Largest radix.
  task automatic test_hex_radix();
    set_alphabet(pack_alphabet("0123456789ABCDEF"), 5'd16);
    send_request(1'b0, 64'h0123_4567_89AB_CDEF);
    send_request(1'b1, 64'hFFFF_FFFF_8000_0000);
    send_request(1'b1, 64'd1);
  endtask

  // Radix that does not divide a power of two.
  task automatic test_decimal_radix();
    set_alphabet(pack_alphabet("0123456789"), 5'd10);
    send_request(1'b0, '1);
    send_request(1'b1, 64'h8000_0000_0000_0000);
    send_request(1'b1, 64'd0);
  endtask

  // Each rejection rule, and junk beyond the used length that is harmless.
  task automatic test_alphabet_rejection();
    set_alphabet(pack_alphabet("0123456789"), 5'd1);
    send_request(1'b0, 64'd7);
    set_alphabet(pack_alphabet("0123456789ABCDEF"), 5'd17);
    send_request(1'b1, random_value());
    set_alphabet(pack_alphabet("0123456789ABCDEF"), 5'd31);
    send_request(1'b0, random_value());
    set_alphabet(pack_alphabet("+123456789"), 5'd10);
    send_request(1'b0, 64'd99);
    set_alphabet(pack_alphabet("01234-6789"), 5'd10);
    send_request(1'b1, random_value());
    set_alphabet(pack_alphabet("0123456789ABCDE"), 5'd16);
    send_request(1'b0, random_value());
    set_alphabet(pack_alphabet("0123456729"), 5'd10);
    send_request(1'b0, 64'd42);
    set_alphabet('1, 5'd16);
    send_request(1'b1, '1);
    set_alphabet(pack_alphabet("01234567-+"), 5'd8);
    send_request(1'b0, 64'o1234567);
  endtask

  // Random alphabets, mostly valid, each with a burst of random requests.
  task automatic test_random_conversions();
    bit make_bad;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      make_bad = ($urandom_range(0, 5) == 0);
      set_random_alphabet(make_bad);
      calm = ($urandom_range(0, 3) == 0);
      repeat (make_bad ? 5 : 20) send_request(1'($urandom_range(0, 1)), random_value());
    end
    calm = 0;
  endtask

  // Digit side: random stalls, with calm stretches of none.
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    dig_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        dig_if.ready <= 1'b0;
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (calm || r < 70) begin
          dig_if.ready <= 1'b1;
        end else begin
          dig_if.ready <= 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  // Compare each digit transaction with the oldest expectation.
  always @(posedge clk) begin
    digit_result_t want;
    if (rst_n && dig_if.valid && dig_if.ready) begin
      if (expected_digits.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected digit: expected none actual char %h last %0d count %0d err %0d",
                 $time, dig_if.digit_char, dig_if.last_digit, dig_if.digit_count,
                 dig_if.alphabet_error);
      end else begin
        want = expected_digits.pop_front();
        check_field("digit_char", want.digit_char, dig_if.digit_char);
        check_field("last_digit", 8'(want.last_digit), 8'(dig_if.last_digit));
        check_field("digit_count", 8'(want.digit_count), 8'(dig_if.digit_count));
        check_field("alphabet_error", 8'(want.alphabet_error), 8'(dig_if.alphabet_error));
      end
    end
  end

  // Watchdog: too long without any transaction ends the run.
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (dig_if.valid && dig_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout after %0d cycles without a transaction", $time, quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    rst_n        <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.cmd   <= 1'b0;
    req_if.value <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_ALPHA_LOW;
    cfg_data     <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_alphabet();
    test_binary_radix();
    test_hex_radix();
    test_decimal_radix();
    test_alphabet_rejection();
    test_random_conversions();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
